// ===== design/wgm_pkg.sv =====
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared constants and cell control types for the glob wildcard matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wgm_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

  localparam logic [7:0] SYM_ANY = 8'h3F;  // '?'
  localparam logic [7:0] SYM_RUN = 8'h2A;  // '*'

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // per-cell control, driven by the sequencer in the top level
  typedef struct packed {
    logic wr_en;    // store the current symbol in this cell
    logic adv_en;   // take the advanced live bit
    logic started;  // a text is in progress: use the held live bit
    logic act;      // cell index below the pattern length
    logic at_end;   // cell index equals the pattern length
  } wgm_cell_ctl_t;

  // per-cell observation of the end position
  typedef struct packed {
    logic adv_end;    // advanced live bit, if this is the end position
    logic start_end;  // start-of-text live bit, if this is the end position
  } wgm_cell_obs_t;

endpackage

`default_nettype wire

// ===== design/wgm_cell.sv =====
// ----------------------------------------------------------------------------
// wgm_cell
// One pattern position: holds its pattern byte, its live bit and the
// all-stars-so-far prefix bit, and passes the closure carry to the right.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_cell (
  input  wire logic                   clk,
  input  wire wgm_pkg::wgm_cell_ctl_t ctl,
  input  wire logic [7:0]             symbol,
  input  wire logic                   carry_in,
  input  wire logic                   allstar_in,
  output logic                        carry_out,
  output logic                        allstar_out,
  output wgm_pkg::wgm_cell_obs_t      obs
);

  logic [7:0] pat_r;
  logic       allstar_r;
  logic       live_r;
  logic       live_nxt;
  logic       is_star;
  logic       hit;
  logic       start_bit;
  logic       cur;

  assign is_star   = (pat_r == wgm_pkg::SYM_RUN);
  assign hit       = (pat_r == wgm_pkg::SYM_ANY) || (pat_r == symbol);
  // position is live at text start when every earlier pattern byte is a star
  assign start_bit = allstar_in & (ctl.act | ctl.at_end);
  assign cur       = ctl.started ? live_r : start_bit;

  // a star keeps its own position live, then closes onward
  assign live_nxt  = carry_in | (cur & is_star & ctl.act);
  assign carry_out = (cur & ctl.act & hit) | (live_nxt & is_star & ctl.act);

  assign allstar_out   = allstar_r;
  assign obs.adv_end   = live_nxt & ctl.at_end;
  assign obs.start_end = start_bit & ctl.at_end;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      pat_r     <= symbol;
      allstar_r <= allstar_in & (symbol == wgm_pkg::SYM_RUN);
    end
    if (ctl.adv_en) begin
      live_r <= live_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/wildcard_glob_matcher_core.sv =====
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_core
// Glob matcher: loads a pattern of up to PATTERN_MAX bytes into a row of
// cells, then streams text bytes through the live-position vector.
// ----------------------------------------------------------------------------
//
//   channel | ports                                             | direction
//   --------+---------------------------------------------------+----------
//   input   | in_valid/in_ready, operation, symbol, last, empty | in
//   result  | out_valid/out_ready, matched, pattern_overflow    | out
//
// One beat is taken per cycle, pattern or text, while in_ready is high.
// The figure is set by the closure carry, a single-bit ripple through the
// row of cells, which settles within the cycle of the text beat.
// A result is registered the cycle after the last text beat (or empty text).
// The input stays open while a result waits, as long as out_ready is high or
// the result register is empty. Reset clears lengths, flags and valids; the
// pattern bytes and live bits need no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_glob_matcher_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_operation,
  input  wire logic [7:0] in_symbol,
  input  wire logic       in_last,
  input  wire logic       in_empty_req,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_matched,
  output logic            out_pattern_overflow
);

  localparam int MAX = wgm_pkg::PATTERN_MAX;
  localparam int LW  = wgm_pkg::LEN_W;

  // control state
  logic [LW-1:0] len_r, len_nxt;
  logic          loading_r, loading_nxt;
  logic          started_r, started_nxt;
  logic          ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_matched_r, out_matched_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic          in_accept;
  logic          pat_beat;
  logic          txt_beat;
  logic          pat_wr;
  logic [LW-1:0] base_len;
  logic          end_full;
  logic          adv_match;
  logic          start_match;

  // chain between cells: carry and all-stars prefix, one entry per position
  logic [MAX:0]            carry;
  logic [MAX:0]            allstar;
  wgm_pkg::wgm_cell_ctl_t  ctl   [MAX];
  wgm_pkg::wgm_cell_obs_t  obs   [MAX];
  logic [MAX-1:0]          adv_end_v;
  logic [MAX-1:0]          start_end_v;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign pat_beat  = in_accept && (in_operation == wgm_pkg::OP_PATTERN);
  assign txt_beat  = in_accept && (in_operation == wgm_pkg::OP_TEXT);

  // a pattern beat outside a load starts a fresh pattern
  assign base_len = loading_r ? len_r : '0;
  assign pat_wr   = pat_beat && !in_empty_req && (base_len < LW'(MAX));

  assign carry[0]   = 1'b0;
  assign allstar[0] = 1'b1;

  for (genvar i = 0; i < MAX; i++) begin : g_cell
    assign ctl[i].wr_en   = pat_wr && (base_len == LW'(i));
    assign ctl[i].adv_en  = txt_beat && !in_empty_req;
    assign ctl[i].started = started_r;
    assign ctl[i].act     = (len_r > LW'(i));
    assign ctl[i].at_end  = (len_r == LW'(i));

    wgm_cell u_cell (
      .clk         (clk),
      .ctl         (ctl[i]),
      .symbol      (in_symbol),
      .carry_in    (carry[i]),
      .allstar_in  (allstar[i]),
      .carry_out   (carry[i+1]),
      .allstar_out (allstar[i+1]),
      .obs         (obs[i])
    );

    assign adv_end_v[i]   = obs[i].adv_end;
    assign start_end_v[i] = obs[i].start_end;
  end

  // the end position past the last cell is seen only on a full store
  assign end_full    = (len_r == LW'(MAX));
  assign adv_match   = (|adv_end_v) | (carry[MAX] & end_full);
  assign start_match = (|start_end_v) | (allstar[MAX] & end_full);

  always_comb begin
    len_nxt         = len_r;
    loading_nxt     = loading_r;
    started_nxt     = started_r;
    ovf_nxt         = ovf_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_matched_nxt = out_matched_r;
    out_ovf_nxt     = out_ovf_r;

    if (pat_beat) begin
      // a pattern beat abandons any text in progress
      started_nxt = 1'b0;
      if (in_empty_req) begin
        len_nxt     = '0;
        ovf_nxt     = 1'b0;
        loading_nxt = 1'b0;
      end else begin
        ovf_nxt     = loading_r ? ovf_r : 1'b0;
        if (pat_wr) begin
          len_nxt = base_len + LW'(1);
        end else begin
          len_nxt = base_len;
          ovf_nxt = 1'b1;
        end
        loading_nxt = !in_last;
      end
    end else if (txt_beat) begin
      loading_nxt = 1'b0;
      if (in_empty_req) begin
        started_nxt     = 1'b0;
        out_valid_nxt   = 1'b1;
        out_matched_nxt = start_match;
        out_ovf_nxt     = ovf_r;
      end else if (in_last) begin
        started_nxt     = 1'b0;
        out_valid_nxt   = 1'b1;
        out_matched_nxt = adv_match;
        out_ovf_nxt     = ovf_r;
      end else begin
        started_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      loading_r   <= 1'b0;
      started_r   <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      loading_r   <= loading_nxt;
      started_r   <= started_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_matched_r <= out_matched_nxt;
    out_ovf_r     <= out_ovf_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_matched          = out_matched_r;
  assign out_pattern_overflow = out_ovf_r;

`ifndef SYNTH
  // length never runs past the store
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MAX))
    else $error("pattern length beyond store");

  // overflow only once the store is full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (len_r == LW'(MAX)))
    else $error("overflow flagged on a partial pattern");

  // a load and a text are never in progress together
  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(started_r && loading_r))
    else $error("load and text both in progress");

  // an empty pattern beat leaves an empty, clean pattern
  a_empty_pat: assert property (@(posedge clk) disable iff (!rst_n)
    (pat_beat && in_empty_req) |=> (len_r == '0) && !ovf_r && !loading_r)
    else $error("empty pattern not cleared");

  // a fresh result follows only a text beat
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && !out_ready)) |-> $past(txt_beat))
    else $error("result without a text beat");
`endif

endmodule

`default_nettype wire
